[rtl/keyframe_bezier_curve_eval_top_macros.svh]
// Assertion macros for the keyframe curve evaluator
`ifndef KEYFRAME_BEZIER_CURVE_EVAL_TOP_MACROS_SVH
`define KEYFRAME_BEZIER_CURVE_EVAL_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define KBC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KBC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KBC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/kbc_pkg.sv]
// ----------------------------------------------------------------------------
// kbc_pkg
// Types and codes shared by the keyframe curve evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package kbc_pkg;
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_EVAL   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_RNG  = 2'd2;
  localparam logic [1:0] ST_DIV0 = 2'd3;

  typedef struct packed {
    logic [15:0]        frame;
    logic signed [31:0] value;
    logic signed [31:0] left;
    logic signed [31:0] right;
  } key_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INS_RD, S_INS_WT, S_INS_CMP, S_INS_PUT,
    S_EV_LAST, S_EV_LASTW, S_EV_SRCH, S_EV_SRCHW, S_EV_SRCHC,
    S_EV_RDA, S_EV_RDB, S_EV_RDBW, S_EV_SETUP, S_EV_P1, S_EV_P2, S_EV_P3, S_EV_MUL,
    S_EV_DIV, S_EV_RND, S_EV_NSET, S_EV_NDIV, S_EV_NRND, S_OUT
  } state_e;
endpackage
`default_nettype wire

[rtl/kbc_if.sv]
// ----------------------------------------------------------------------------
// kbc_req_if / kbc_rsp_if
// Valid/ready channels of the keyframe curve evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface kbc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] key_frame;
  logic signed [31:0] key_value;
  logic signed [31:0] left_handle;
  logic signed [31:0] right_handle;
  logic [15:0] eval_frame;
  logic        normalize;
  modport source (output valid, req_type, key_frame, key_value, left_handle,
                  right_handle, eval_frame, normalize, input ready);
  modport sink (input valid, req_type, key_frame, key_value, left_handle,
                right_handle, eval_frame, normalize, output ready);
endinterface

interface kbc_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] curve_value;
  logic [1:0]  status;
  modport source (output valid, curve_value, status, input ready);
  modport sink (input valid, curve_value, status, output ready);
endinterface
`default_nettype wire

[rtl/keyframe_bezier_curve_eval_top.sv]
// ----------------------------------------------------------------------------
// keyframe_bezier_curve_eval_top
// Sorted keyframe table in one RAM with a cubic Bezier evaluator.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// req       in   req_type, key_frame, key_value, handles, eval_frame, normalize
// rsp       out  curve_value, status
//
// Clear and rejected requests go straight to the response. Insert moves each
// larger key up one place (shift loop over the single-port table RAM), then
// writes the new key. Evaluate scans the keys for the segment, then forms the
// split products and runs the 128-step restoring divider; normalising adds a second division.
// The table RAM needs no clearing: only entries below the key count are read.
// A held result stalls the next request until it is transferred.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "keyframe_bezier_curve_eval_top_macros.svh"
module keyframe_bezier_curve_eval_top
  import kbc_pkg::*;
#(
  parameter int MAX_KEYS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  kbc_req_if.sink    req_i,
  kbc_rsp_if.source  rsp_o
);
  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);

  // table RAM, one port, registered read
  key_t          mem [MAX_KEYS];
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  key_t          mem_wdata, mem_rdata_q;
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata_q <= mem[mem_addr];
  end

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, pos_q, pos_d, j_q, j_d;
  logic [CW-1:0] seg_q, seg_d;
  logic signed [31:0] min_q, min_d, max_q, max_d;
  // held request
  logic [15:0] kf_q, kf_d, ef_q, ef_d;
  logic signed [31:0] kv_q, kv_d, kl_q, kl_d, kr_q, kr_d;
  logic nrm_q, nrm_d;
  key_t a_q, a_d;
  logic signed [17:0] df_q, df_d, tm_q, tm_d;   // df may be negative
  logic [16:0] tot_q, tot_d;
  logic signed [55:0] w_q [4];
  logic signed [55:0] w_d [4];
  logic [1:0] mi_q, mi_d;
  logic ph_q, ph_d;
  logic signed [127:0] acc_q, acc_d;
  logic [127:0] num_q, num_d;
  logic [63:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [40:0] quo_q, quo_d;
  logic neg_q, neg_d;
  logic [6:0] it_q, it_d;
  logic signed [31:0] y_q, y_d;
  logic [1:0] st_q, st_d;
  logic ov_q, ov_d;

  // weight times value, split into low and high halves of the weight
  logic signed [31:0] mop;
  logic signed [28:0] wop;
  logic signed [60:0] prod;
  always_comb begin
    case (mi_q)
      2'd0: mop = a_q.value;
      2'd1: mop = a_q.right;
      2'd2: mop = mem_rdata_q.left;
      default: mop = mem_rdata_q.value;
    endcase
    wop  = ph_q ? $signed({w_q[mi_q][55], w_q[mi_q][55:28]})
                : $signed({1'b0, w_q[mi_q][27:0]});
    prod = wop * mop;
  end

  // one restoring divide step
  logic [64:0] trial;
  logic [63:0] rsh;
  always_comb begin
    rsh   = {rem_q[62:0], num_q[127]};
    trial = {1'b0, rsh} - {1'b0, dvs_q};
  end

  always_comb begin
    logic signed [63:0] sy;
    logic signed [33:0] rng;
    state_d = state_q;
    cnt_d = cnt_q; pos_d = pos_q; j_d = j_q; seg_d = seg_q;
    min_d = min_q; max_d = max_q;
    kf_d = kf_q; ef_d = ef_q; kv_d = kv_q; kl_d = kl_q; kr_d = kr_q; nrm_d = nrm_q;
    a_d = a_q; df_d = df_q; tm_d = tm_q; tot_d = tot_q;
    w_d = w_q; mi_d = mi_q; ph_d = ph_q; acc_d = acc_q; num_d = num_q; rem_d = rem_q;
    dvs_d = dvs_q; quo_d = quo_q; neg_d = neg_q; it_d = it_q; y_d = y_q;
    st_d = st_q; ov_d = ov_q;
    mem_we = 1'b0; mem_addr = '0;
    mem_wdata = '{frame: kf_q, value: kv_q, left: kl_q, right: kr_q};
    req_i.ready = 1'b0;
    sy = '0; rng = '0;
    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          kf_d = req_i.key_frame; kv_d = req_i.key_value;
          kl_d = req_i.left_handle; kr_d = req_i.right_handle;
          ef_d = req_i.eval_frame; nrm_d = req_i.normalize;
          y_d = '0; st_d = ST_OK; state_d = S_OUT;
          case (req_i.req_type)
            REQ_CLEAR: begin
              cnt_d = '0; min_d = '0; max_d = '0;
            end
            REQ_INSERT: begin
              if (cnt_q >= CW'(MAX_KEYS)) st_d = ST_FULL;
              else begin
                pos_d = cnt_q; state_d = S_INS_RD;
              end
            end
            REQ_EVAL: begin
              if (cnt_q < CW'(2)) st_d = ST_RNG;
              else state_d = S_EV_LAST;
            end
            default: ;
          endcase
        end
      end
      S_INS_RD: begin
        if (pos_q == '0) state_d = S_INS_PUT;
        else begin
          mem_addr = AW'(pos_q - CW'(1)); state_d = S_INS_WT;
        end
      end
      S_INS_WT: begin
        mem_addr = AW'(pos_q - CW'(1)); state_d = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (mem_rdata_q.frame > kf_q) begin
          mem_we = 1'b1; mem_addr = AW'(pos_q); mem_wdata = mem_rdata_q;
          pos_d = pos_q - CW'(1); state_d = S_INS_RD;
        end else state_d = S_INS_PUT;
      end
      S_INS_PUT: begin
        mem_we = 1'b1; mem_addr = AW'(pos_q);
        if (cnt_q == '0) begin
          min_d = kv_q; max_d = kv_q;
        end else begin
          if (kv_q < min_q) min_d = kv_q;
          if (kv_q > max_q) max_d = kv_q;
        end
        cnt_d = cnt_q + CW'(1);
        state_d = S_OUT;
      end
      S_EV_LAST: begin
        mem_addr = AW'(cnt_q - CW'(1)); state_d = S_EV_LASTW;
      end
      S_EV_LASTW: begin
        mem_addr = AW'(cnt_q - CW'(1)); state_d = S_EV_SRCH;
      end
      S_EV_SRCH: begin
        // the single visit checks the last key, then the scan over j starts
        if (j_q == '0 && seg_q == '0 && ef_q >= mem_rdata_q.frame && !ov_q) begin
          st_d = ST_RNG; state_d = S_OUT;
        end else begin
          ov_d = 1'b1;
          mem_addr = AW'(j_q); state_d = S_EV_SRCHW;
        end
      end
      S_EV_SRCHW: begin
        mem_addr = AW'(j_q); state_d = S_EV_SRCHC;
      end
      S_EV_SRCHC: begin
        // entries are sorted: the last j with frame[j] <= f starts the segment
        if (ef_q >= mem_rdata_q.frame && j_q + CW'(1) < cnt_q) seg_d = j_q;
        if (j_q + CW'(2) < cnt_q) begin
          j_d = j_q + CW'(1); mem_addr = AW'(j_q + CW'(1)); state_d = S_EV_SRCHW;
        end else state_d = S_EV_RDA;
      end
      S_EV_RDA: begin
        mem_addr = AW'(seg_q); state_d = S_EV_RDB;
      end
      S_EV_RDB: begin
        a_d = mem_rdata_q; mem_addr = AW'(seg_q + CW'(1)); state_d = S_EV_RDBW;
      end
      S_EV_RDBW: begin
        mem_addr = AW'(seg_q + CW'(1)); state_d = S_EV_SETUP;
      end
      S_EV_SETUP: begin
        df_d = $signed({2'b0, ef_q}) - $signed({2'b0, a_q.frame});
        tot_d = {1'b0, mem_rdata_q.frame} - {1'b0, a_q.frame};
        tm_d = $signed({1'b0, tot_d}) - df_d;
        mem_addr = AW'(seg_q + CW'(1));
        if (mem_rdata_q.frame <= a_q.frame) begin
          st_d = ST_DIV0; state_d = S_OUT;
        end else state_d = S_EV_P1;
      end
      S_EV_P1: begin
        mem_addr = AW'(seg_q + CW'(1));
        w_d[0] = 56'(tm_q * tm_q); w_d[1] = 56'(tm_q * df_q);
        w_d[2] = 56'(df_q * df_q); w_d[3] = 56'({1'b0, tot_q} * {1'b0, tot_q});
        state_d = S_EV_P2;
      end
      S_EV_P2: begin
        mem_addr = AW'(seg_q + CW'(1));
        // divisor tot^3; weights tm^3, tm^2 df, tm df^2, df^3
        dvs_d = 64'(w_q[3] * $signed({1'b0, tot_q}));
        w_d[0] = 56'(w_q[0] * tm_q);
        w_d[1] = 56'(w_q[1] * tm_q);
        w_d[2] = 56'(w_q[2] * tm_q);
        w_d[3] = 56'(w_q[2] * df_q);
        state_d = S_EV_P3;
      end
      S_EV_P3: begin
        mem_addr = AW'(seg_q + CW'(1));
        w_d[1] = 56'(w_q[1] * 3);
        w_d[2] = 56'(w_q[2] * 3);
        mi_d = 2'd0; ph_d = 1'b0; acc_d = '0;
        state_d = S_EV_MUL;
      end
      S_EV_MUL: begin
        // low half of the weight first, then the high half shifted up
        mem_addr = AW'(seg_q + CW'(1));
        if (ph_q) acc_d = acc_q + ({{67{prod[60]}}, prod} << 28);
        else acc_d = acc_q + {{67{prod[60]}}, prod};
        ph_d = !ph_q;
        if (ph_q) begin
          mi_d = mi_q + 2'd1;
          if (mi_q == 2'd3) begin
            neg_d = acc_d[127];
            num_d = acc_d[127] ? 128'(-acc_d) : 128'(acc_d);
            rem_d = '0; quo_d = '0; it_d = '0;
            state_d = S_EV_DIV;
          end
        end
      end
      S_EV_DIV: begin
        num_d = {num_q[126:0], 1'b0};
        if (!trial[64]) begin
          rem_d = trial[63:0];
          quo_d = ({quo_q[39:0], 1'b1} > 41'(64'h100_0000_0000)) ? 41'h100_0000_0000
                                                                 : {quo_q[39:0], 1'b1};
        end else begin
          rem_d = rsh;
          quo_d = ({quo_q[39:0], 1'b0} > 41'(64'h100_0000_0000)) ? 41'h100_0000_0000
                                                                 : {quo_q[39:0], 1'b0};
        end
        if (quo_q > 41'h0FF_FFFF_FFFF) quo_d = 41'h100_0000_0000;
        it_d = it_q + 7'd1;
        if (it_q == 7'd127) state_d = S_EV_RND;
      end
      S_EV_RND: begin
        sy = $signed({23'b0, quo_q}) + (({rem_q, 1'b0} >= {1'b0, dvs_q}) ? 64'sd1 : 64'sd0);
        if (neg_q) sy = -sy;
        if (sy > 64'sh7FFF_FFFF) y_d = 32'sh7FFF_FFFF;
        else if (sy < -64'sh8000_0000) y_d = -32'sh8000_0000;
        else y_d = sy[31:0];
        state_d = nrm_q ? S_EV_NSET : S_OUT;
      end
      S_EV_NSET: begin
        rng = $signed({max_q[31], max_q}) - $signed({min_q[31], min_q});
        if (rng <= 0) begin
          st_d = ST_DIV0; y_d = '0; state_d = S_OUT;
        end else begin
          sy = ($signed({{32{y_q[31]}}, y_q}) - $signed({{32{min_q[31]}}, min_q}))
               <<< FRAC_BITS;
          neg_d = sy[63];
          num_d = {(sy[63] ? 64'(-sy) : 64'(sy)), 64'b0};
          dvs_d = 64'(rng);
          rem_d = '0; quo_d = '0; it_d = 7'd64;
          state_d = S_EV_NDIV;
        end
      end
      S_EV_NDIV: begin
        num_d = {num_q[126:0], 1'b0};
        // hold the quotient once past 2^40: the result saturates anyway
        quo_d = quo_q[40] ? quo_q : {quo_q[39:0], !trial[64]};
        rem_d = trial[64] ? rsh : trial[63:0];
        it_d = it_q + 7'd1;
        if (it_q == 7'd127) state_d = S_EV_NRND;
      end
      S_EV_NRND: begin
        sy = $signed({23'b0, quo_q}) + (({rem_q, 1'b0} >= {1'b0, dvs_q}) ? 64'sd1 : 64'sd0);
        if (neg_q) sy = -sy;
        if (sy > 64'sh7FFF_FFFF) y_d = 32'sh7FFF_FFFF;
        else if (sy < -64'sh8000_0000) y_d = -32'sh8000_0000;
        else y_d = sy[31:0];
        state_d = S_OUT;
      end
      S_OUT: begin
        if (rsp_o.ready) begin
          state_d = S_IDLE; j_d = '0; seg_d = '0; ov_d = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign rsp_o.valid       = (state_q == S_OUT);
  assign rsp_o.curve_value = (st_q == ST_OK) ? y_q : 32'sd0;
  assign rsp_o.status      = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; min_q <= '0; max_q <= '0;
      j_q <= '0; seg_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; min_q <= min_d; max_q <= max_d;
      j_q <= j_d; seg_q <= seg_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; kf_q <= kf_d; ef_q <= ef_d; kv_q <= kv_d; kl_q <= kl_d;
    kr_q <= kr_d; nrm_q <= nrm_d; a_q <= a_d; df_q <= df_d; tm_q <= tm_d;
    tot_q <= tot_d; w_q <= w_d; mi_q <= mi_d; ph_q <= ph_d; acc_q <= acc_d;
    num_q <= num_d; rem_q <= rem_d; dvs_q <= dvs_d; quo_q <= quo_d; neg_q <= neg_d;
    it_q <= it_d; y_q <= y_d; st_q <= st_d;
  end

  `KBC_ASSERT_IMP(a_no_ready_busy, clk_i, rst_ni, state_q != S_IDLE, !req_i.ready)
  `KBC_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(MAX_KEYS))
  `KBC_ASSERT_NXT(a_full_no_grow, clk_i, rst_ni,
                  state_q == S_IDLE && req_i.valid && req_i.req_type == REQ_INSERT
                  && cnt_q == CW'(MAX_KEYS), cnt_q == CW'(MAX_KEYS))
endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe curve evaluator testbench
// Feeds clear, insert and evaluate requests through the request channel and
// checks every response against a cycle-free model of the keyframe table and
// its cubic Bezier evaluation, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import kbc_pkg::*;

  localparam int NUM_KEYS     = 64;
  localparam int IDLE_LIMIT   = 20000;
  localparam int TAIL_CYCLES  = 400;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [1:0]         req_type;
    logic [15:0]        key_frame;
    logic signed [31:0] key_value;
    logic signed [31:0] left_handle;
    logic signed [31:0] right_handle;
    logic [15:0]        eval_frame;
    logic               normalize;
    bit                 drain_first; // hold off until all responses are in
  } request_t;

  typedef struct {
    logic signed [31:0] curve_value;
    logic [1:0]         status;
  } response_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  kbc_req_if req_if ();
  kbc_rsp_if rsp_if ();

  keyframe_bezier_curve_eval_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  always #4 clk_i = ~clk_i;

  request_t  pending_q[$];
  response_t curve_q[$];
  int        accepted_cnt = 0;
  int        mismatch_cnt = 0;
  int        idle_cycles  = 0;

  // Shadow copy of the keyframe table and value range
  key_t   shadow_keys[NUM_KEYS];
  int     shadow_count = 0;
  longint shadow_min = 0;
  longint shadow_max = 0;

  // Idle percentages per phase: receiver idles most first, then sender, then none
  function automatic int sender_idle_pct();
    if (accepted_cnt < 160) return 11;
    if (accepted_cnt < 320) return 55;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (accepted_cnt < 160) return 55;
    if (accepted_cnt < 320) return 11;
    return 0;
  endfunction

  // Rounded quotient, ties away from zero; divisor is positive
  function automatic logic signed [127:0] round_quotient(logic signed [127:0] num,
                                                         logic signed [127:0] den);
    logic signed [127:0] mag;
    logic signed [127:0] quo;
    logic signed [127:0] rem;
    mag = (num < 0) ? -num : num;
    quo = mag / den;
    rem = mag % den;
    if (2 * rem >= den) quo = quo + 1;
    return (num < 0) ? -quo : quo;
  endfunction

  function automatic longint clamp32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 64'sd2147483647;
    if (v < -128'sd2147483648) return -64'sd2147483648;
    return longint'(v);
  endfunction

  function automatic response_t eval_curve(request_t rq);
    response_t rsp;
    longint f, df, span, tm, y, va, vr, vl, vb;
    int seg;
    logic signed [127:0] acc;
    rsp.curve_value = '0;
    rsp.status = ST_OK;
    f = rq.eval_frame;
    if (shadow_count < 2 || f >= shadow_keys[shadow_count-1].frame) begin
      rsp.status = ST_RNG;
      return rsp;
    end
    // Last segment containing the frame; segment 0 when before the first key
    seg = 0;
    for (int j = 0; j + 1 < shadow_count; j++)
      if (f >= shadow_keys[j].frame && f < shadow_keys[j+1].frame) seg = j;
    df   = f - longint'(shadow_keys[seg].frame);
    span = longint'(shadow_keys[seg+1].frame) - longint'(shadow_keys[seg].frame);
    if (span <= 0) begin
      rsp.status = ST_DIV0;
      return rsp;
    end
    tm = span - df;
    va = shadow_keys[seg].value;
    vr = shadow_keys[seg].right;
    vl = shadow_keys[seg+1].left;
    vb = shadow_keys[seg+1].value;
    acc = 128'(tm*tm*tm) * va + 128'(3*tm*tm*df) * vr
        + 128'(3*tm*df*df) * vl + 128'(df*df*df) * vb;
    y = clamp32(round_quotient(acc, 128'(span*span*span)));
    if (rq.normalize) begin
      if (shadow_max - shadow_min <= 0) begin
        rsp.status = ST_DIV0;
        return rsp;
      end
      y = clamp32(round_quotient(128'(y - shadow_min) * 65536,
                                 128'(shadow_max - shadow_min)));
    end
    rsp.curve_value = y[31:0];
    return rsp;
  endfunction

  // Advance the shadow state by one request and give its response
  function automatic response_t apply_request(request_t rq);
    response_t rsp;
    int pos;
    longint v;
    rsp.curve_value = '0;
    rsp.status = ST_OK;
    case (rq.req_type)
      REQ_CLEAR: begin
        shadow_count = 0;
        shadow_min = 0;
        shadow_max = 0;
      end
      REQ_INSERT: begin
        if (shadow_count >= NUM_KEYS) begin
          rsp.status = ST_FULL;
        end else begin
          // Equal frames: the new key goes after existing ones
          pos = shadow_count;
          while (pos > 0 && shadow_keys[pos-1].frame > rq.key_frame) begin
            shadow_keys[pos] = shadow_keys[pos-1];
            pos--;
          end
          shadow_keys[pos] = '{rq.key_frame, rq.key_value, rq.left_handle,
                               rq.right_handle};
          v = rq.key_value;
          if (shadow_count == 0) begin
            shadow_min = v;
            shadow_max = v;
          end else begin
            if (v < shadow_min) shadow_min = v;
            if (v > shadow_max) shadow_max = v;
          end
          shadow_count++;
        end
      end
      REQ_EVAL: rsp = eval_curve(rq);
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic request_t make_req(logic [1:0] kind, int frame, int value,
                                        int lh, int rh, int eval_at, bit norm);
    request_t rq;
    rq.req_type     = kind;
    rq.key_frame    = frame[15:0];
    rq.key_value    = value;
    rq.left_handle  = lh;
    rq.right_handle = rh;
    rq.eval_frame   = eval_at[15:0];
    rq.normalize    = norm;
    rq.drain_first  = 1'b0;
    return rq;
  endfunction

  function automatic int rand_value(bit full);
    if (full) return int'($urandom);
    return int'($urandom_range(2097152)) - 1048576;
  endfunction

  // Driver: advance the queue on each transfer, hold valid while stalled
  always @(posedge clk_i) begin
    bit drive;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        curve_q.push_back(apply_request(pending_q[0]));
        void'(pending_q.pop_front());
        accepted_cnt++;
      end
      if (!(req_if.valid && !req_if.ready)) begin
        drive = 1'b0;
        if (pending_q.size() > 0 && !(pending_q[0].drain_first && curve_q.size() != 0)
            && $urandom_range(99) >= sender_idle_pct())
          drive = 1'b1;
        req_if.valid <= drive;
        if (drive) begin
          req_if.req_type     <= pending_q[0].req_type;
          req_if.key_frame    <= pending_q[0].key_frame;
          req_if.key_value    <= pending_q[0].key_value;
          req_if.left_handle  <= pending_q[0].left_handle;
          req_if.right_handle <= pending_q[0].right_handle;
          req_if.eval_frame   <= pending_q[0].eval_frame;
          req_if.normalize    <= pending_q[0].normalize;
        end
      end
    end
  end

  // Monitor: compare each response transfer with the oldest prediction
  always @(posedge clk_i) begin
    response_t exp_rsp;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (curve_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_LIMIT)
            $display("unexpected response: value %0d status %0d",
                     rsp_if.curve_value, rsp_if.status);
        end else begin
          exp_rsp = curve_q.pop_front();
          if (rsp_if.curve_value !== exp_rsp.curve_value
              || rsp_if.status !== exp_rsp.status) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_LIMIT)
              $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                       exp_rsp.curve_value, exp_rsp.status,
                       rsp_if.curve_value, rsp_if.status);
          end
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // Watchdog: drop out if no transfer happens for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    request_t rq;
    int nkeys, nevals, last_frame;
    bit wide_frames, full_values;
    // Hold every input at a known level before reset lifts
    req_if.valid = 1'b0;
    req_if.req_type = REQ_CLEAR;
    req_if.key_frame = '0;
    req_if.key_value = '0;
    req_if.left_handle = '0;
    req_if.right_handle = '0;
    req_if.eval_frame = '0;
    req_if.normalize = 1'b0;
    rsp_if.ready = 1'b0;

    // Directed: empty table, single key, equal frames, extremes
    pending_q.push_back(make_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_req(REQ_EVAL, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_req(REQ_INSERT, 100, 32'h7fffffff, 32'h80000000,
                                 32'h7fffffff, 0, 0));
    pending_q.push_back(make_req(REQ_EVAL, 0, 0, 0, 0, 100, 1));
    pending_q.push_back(make_req(REQ_INSERT, 100, 32'h80000000, 32'h7fffffff,
                                 32'h80000000, 0, 0));
    pending_q.push_back(make_req(REQ_EVAL, 0, 0, 0, 0, 50, 0));
    pending_q.push_back(make_req(REQ_INSERT, 300, 65536, 32'h80000000, 32'h7fffffff,
                                 0, 0));
    pending_q.push_back(make_req(REQ_INSERT, 65535, 0, 32'h7fffffff, 32'h80000000,
                                 0, 0));
    pending_q.push_back(make_req(REQ_EVAL, 0, 0, 0, 0, 100, 0));
    pending_q.push_back(make_req(REQ_EVAL, 0, 0, 0, 0, 200, 1));
    pending_q.push_back(make_req(REQ_EVAL, 0, 0, 0, 0, 65534, 1));
    pending_q.push_back(make_req(REQ_EVAL, 0, 0, 0, 0, 65535, 0));
    pending_q.push_back(make_req(2'd3, 65535, -1, -1, -1, 65535, 1));
    // Extrapolation before the first key, with key frame zero present later
    pending_q.push_back(make_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_req(REQ_INSERT, 20, 262144, -65536, 131072, 0, 0));
    pending_q.push_back(make_req(REQ_INSERT, 10, -196608, 65536, 0, 0, 0));
    pending_q.push_back(make_req(REQ_EVAL, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_req(REQ_EVAL, 0, 0, 0, 0, 15, 1));
    pending_q.push_back(make_req(REQ_INSERT, 0, 5, 5, 5, 0, 0));
    pending_q.push_back(make_req(REQ_EVAL, 0, 0, 0, 0, 5, 0));
    // Flat range under normalisation; wait for the table to settle first
    rq = make_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
    rq.drain_first = 1'b1;
    pending_q.push_back(rq);
    pending_q.push_back(make_req(REQ_INSERT, 5, 7, 1, 2, 0, 0));
    pending_q.push_back(make_req(REQ_INSERT, 9, 7, 3, 4, 0, 0));
    pending_q.push_back(make_req(REQ_EVAL, 0, 0, 0, 0, 6, 1));
    pending_q.push_back(make_req(REQ_EVAL, 0, 0, 0, 0, 6, 0));

    // Random: build a table, then evaluate across it, with some noise
    while (pending_q.size() < 420) begin
      if ($urandom_range(9) != 0)
        pending_q.push_back(make_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
      nkeys = ($urandom_range(7) == 0) ? 66 : $urandom_range(12, 1);
      wide_frames = ($urandom_range(4) == 0);
      full_values = ($urandom_range(2) == 0);
      last_frame = 0;
      for (int k = 0; k < nkeys; k++) begin
        rq = make_req(REQ_INSERT,
                      wide_frames ? int'($urandom_range(65535)) : int'($urandom_range(300)),
                      rand_value(full_values), rand_value(full_values),
                      rand_value(full_values), int'($urandom_range(65535)),
                      $urandom_range(1));
        if (rq.key_frame > last_frame) last_frame = rq.key_frame;
        pending_q.push_back(rq);
      end
      nevals = $urandom_range(10, 2);
      for (int e = 0; e < nevals; e++) begin
        rq = make_req(REQ_EVAL, int'($urandom_range(65535)), int'($urandom),
                      int'($urandom), int'($urandom),
                      ($urandom_range(5) == 0) ? int'($urandom_range(65535))
                                               : int'($urandom_range(last_frame + 5)),
                      $urandom_range(1));
        if ($urandom_range(19) == 0) rq.req_type = 2'd3;
        pending_q.push_back(rq);
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_q.size() == 0 && curve_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && curve_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
